// ===== src/mfe_pkg.sv =====
// shared types, constants and rounding helpers of the multitap feedback echo
package mfe_pkg;

  localparam int DELAY_DEPTH_DEF = 65536;
  localparam int MAX_TAPS_DEF    = 10;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 16;
  localparam int ACC_W    = 48;
  localparam int SUM_W    = 68;
  localparam int MUL_AW   = 25;
  localparam int MUL_BW   = 17;
  localparam int PROD_W   = 43;
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 64;
  localparam int SET_W    = 48;

  localparam logic [COEF_W-1:0] GAIN_RST  = 16'd4096;
  localparam logic [COEF_W-1:0] DRY_RST   = 16'd32768;
  localparam logic [COEF_W-1:0] FDLY_RST  = 16'd1;

  localparam logic signed [SUM_W-1:0] SAT_HI = 68'sd8388607;
  localparam logic signed [SUM_W-1:0] SAT_LO = -68'sd8388608;

  typedef enum logic [2:0] {
    REG_INPUT_GAIN   = 3'd0,
    REG_DRY_MIX      = 3'd1,
    REG_WET_MIX      = 3'd2,
    REG_FINAL_FB     = 3'd3,
    REG_FINAL_DELAY  = 3'd4,
    REG_TAP_COUNT    = 3'd5,
    REG_TAP_SELECT   = 3'd6,
    REG_TAP_SETTING  = 3'd7
  } reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_GAIN, ST_GSAT, ST_DQ, ST_DR, ST_DA, ST_DS, ST_RD, ST_RV,
    ST_MD, ST_MF, ST_F0, ST_F1, ST_F2, ST_F3, ST_O1, ST_O2, ST_O3
  } state_e;

  // add one half, arithmetic shift, clamp to 24 bits
  function automatic logic signed [SAMPLE_W-1:0] rnd_sat(
    input logic signed [SUM_W-1:0] v,
    input int unsigned sh
  );
    logic signed [SUM_W-1:0] t;
    t = v + $signed(SUM_W'(1) << (sh - 1));
    t = t >>> sh;
    if (t > SAT_HI) begin
      return SAT_HI[SAMPLE_W-1:0];
    end else if (t < SAT_LO) begin
      return SAT_LO[SAMPLE_W-1:0];
    end
    return t[SAMPLE_W-1:0];
  endfunction

endpackage

// ===== src/mfe_if.sv =====
// sample stream interfaces for input and output channels
interface mfe_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mfe_pkg::SAMPLE_W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface mfe_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mfe_pkg::SAMPLE_W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== src/multitap_feedback_echo_unit.sv =====
// multitap feedback echo top level with shared multiplier sequencer
//
//  channel   dir  handshake        payload
//  in_s      in   valid/ready      sample_in  s24 Q1.23
//  out_s     out  valid/ready      sample_out s24 Q1.23
//  apb       in   psel/penable     8 regs at 8*i, 64-bit data
//
// the single 25x17 multiplier and the single-port line memory are each used at most
// once per step of the sequencer
// reset clears control, config and per-line fill counters; lines need no clearing pass
// a finished sample waits in the output register while the next one is accepted
// a stalled output holds the sequencer in its last step until the slot frees
module multitap_feedback_echo_unit #(
  parameter int DELAY_DEPTH = mfe_pkg::DELAY_DEPTH_DEF,
  parameter int MAX_TAPS    = mfe_pkg::MAX_TAPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mfe_in_if.sink                      in_s,
  mfe_out_if.source                   out_s,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mfe_pkg::ADDR_W-1:0]  paddr,
  input  logic [mfe_pkg::DATA_W-1:0]  pwdata,
  output logic [mfe_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int SW        = mfe_pkg::SAMPLE_W;
  localparam int CW        = mfe_pkg::COEF_W;
  localparam int AW        = $clog2(DELAY_DEPTH);
  localparam int NUM_LINES = MAX_TAPS + 1;
  localparam int LW        = $clog2(NUM_LINES);
  localparam int IW        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int MEM_DEPTH = NUM_LINES * DELAY_DEPTH;
  localparam int MW        = $clog2(MEM_DEPTH);
  localparam int DW        = ((AW > 16) ? AW : 16) + 1;
  localparam int RS        = 16 + AW;
  localparam bit NEED_MOD  = DELAY_DEPTH < 65536;
  localparam logic [mfe_pkg::MUL_BW-1:0] RECIP =
    mfe_pkg::MUL_BW'((64'd1 << RS) / DELAY_DEPTH);
  localparam logic [AW:0] DEPTH_C = (AW + 1)'(DELAY_DEPTH);
  localparam logic [MW-1:0] FINAL_BASE = MW'(MAX_TAPS * DELAY_DEPTH);
  localparam int CMPW = LW + 5;

  // configuration
  logic [CW-1:0]            gain_q, dry_q, wet_q, ffb_q, fdly_q;
  logic [3:0]               tcnt_q, tsel_q;
  logic [mfe_pkg::SET_W-1:0] tset_q;
  logic [mfe_pkg::SET_W-1:0] tap_tab_q [MAX_TAPS];

  // sequencer and line bookkeeping
  mfe_pkg::state_e state_q, state_d;
  logic [LW-1:0]  t_q;
  logic           fin_q;
  logic [AW-1:0]  ptr_q;
  logic [AW-1:0]  cp_q  [NUM_LINES];
  logic [AW:0]    cnt_q [NUM_LINES];
  logic [MW-1:0]  base_q;
  logic           out_vld_q;
  logic signed [SW-1:0] out_q;

  // datapath
  logic signed [SW-1:0]                x_q, g_q, rdata_q, v_q;
  logic signed [mfe_pkg::PROD_W-1:0]   preg_q;
  logic signed [mfe_pkg::ACC_W-1:0]    acc_q, wide_q;
  logic signed [mfe_pkg::SUM_W-1:0]    sum_q;
  logic [AW-1:0]                       r_q, s_q;
  logic                                vld_q;
  logic [SW-1:0]                       echo_mem [MEM_DEPTH];

  // combinational
  logic                                mul_en, mem_re, mem_we, cfg_wr, last_tap;
  logic signed [mfe_pkg::MUL_AW-1:0]   mul_a;
  logic [mfe_pkg::MUL_BW-1:0]          mul_b;
  logic signed [mfe_pkg::PROD_W-1:0]   prod;
  logic [MW-1:0]                       mem_raddr, mem_waddr;
  logic signed [SW-1:0]                mem_wdata, v, y;
  logic [CW-1:0]                       cur_d, fd;
  logic [LW-1:0]                       cur_ln;
  logic [DW-1:0]                       rdiff;
  logic [AW:0]                         ssum, pdiff;
  logic [3:0]                          ncnt;
  logic                                out_free;
  mfe_pkg::reg_e                       ridx;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign ridx     = mfe_pkg::reg_e'(paddr[5:3]);
  assign in_s.ready = (state_q == mfe_pkg::ST_IDLE);
  assign out_s.valid = out_vld_q;
  assign out_s.sample_out = out_q;
  assign out_free = !out_vld_q || out_s.ready;

  assign fd     = (fdly_q == '0) ? CW'(1) : fdly_q;
  assign cur_d  = fin_q ? fd : tap_tab_q[t_q[IW-1:0]][47:32];
  assign cur_ln = fin_q ? LW'(MAX_TAPS) : t_q;
  assign v      = vld_q ? rdata_q : '0;
  assign last_tap = (CMPW'(t_q) + CMPW'(1)) >= CMPW'(tcnt_q);
  assign ncnt   = ({1'b0, pwdata[3:0]} > 5'(MAX_TAPS)) ? 4'(MAX_TAPS) : pwdata[3:0];

  assign prod = mul_a * $signed({1'b0, mul_b});

  // register read back
  always_comb begin
    prdata = '0;
    unique case (ridx)
      mfe_pkg::REG_INPUT_GAIN:  prdata = mfe_pkg::DATA_W'(gain_q);
      mfe_pkg::REG_DRY_MIX:     prdata = mfe_pkg::DATA_W'(dry_q);
      mfe_pkg::REG_WET_MIX:     prdata = mfe_pkg::DATA_W'(wet_q);
      mfe_pkg::REG_FINAL_FB:    prdata = mfe_pkg::DATA_W'(ffb_q);
      mfe_pkg::REG_FINAL_DELAY: prdata = mfe_pkg::DATA_W'(fdly_q);
      mfe_pkg::REG_TAP_COUNT:   prdata = mfe_pkg::DATA_W'(tcnt_q);
      mfe_pkg::REG_TAP_SELECT:  prdata = mfe_pkg::DATA_W'(tsel_q);
      mfe_pkg::REG_TAP_SETTING: prdata = mfe_pkg::DATA_W'(tset_q);
      default:                  prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mfe_pkg::ST_IDLE: if (in_s.valid) state_d = mfe_pkg::ST_GAIN;
      mfe_pkg::ST_GAIN: state_d = mfe_pkg::ST_GSAT;
      mfe_pkg::ST_GSAT: state_d = mfe_pkg::ST_DQ;
      mfe_pkg::ST_DQ:   state_d = mfe_pkg::ST_DR;
      mfe_pkg::ST_DR:   state_d = mfe_pkg::ST_DA;
      mfe_pkg::ST_DA:   state_d = mfe_pkg::ST_DS;
      mfe_pkg::ST_DS:   state_d = mfe_pkg::ST_RD;
      mfe_pkg::ST_RD:   state_d = mfe_pkg::ST_RV;
      mfe_pkg::ST_RV:   state_d = fin_q ? mfe_pkg::ST_F0 : mfe_pkg::ST_MD;
      mfe_pkg::ST_MD:   state_d = mfe_pkg::ST_MF;
      mfe_pkg::ST_MF:   state_d = mfe_pkg::ST_DQ;
      mfe_pkg::ST_F0:   state_d = mfe_pkg::ST_F1;
      mfe_pkg::ST_F1:   state_d = mfe_pkg::ST_F2;
      mfe_pkg::ST_F2:   state_d = mfe_pkg::ST_F3;
      mfe_pkg::ST_F3:   state_d = mfe_pkg::ST_O1;
      mfe_pkg::ST_O1:   state_d = mfe_pkg::ST_O2;
      mfe_pkg::ST_O2:   state_d = mfe_pkg::ST_O3;
      mfe_pkg::ST_O3:   if (out_free) state_d = mfe_pkg::ST_IDLE;
      default:          state_d = mfe_pkg::ST_IDLE;
    endcase
  end

  // multiplier operands and memory controls per step
  always_comb begin
    mul_en    = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = (fin_q ? FINAL_BASE : base_q) + MW'(s_q);
    mem_waddr = base_q + MW'(ptr_q);
    mem_wdata = '0;
    y         = mfe_pkg::rnd_sat(sum_q + (mfe_pkg::SUM_W'(preg_q) <<< 24), 30);
    unique case (state_q)
      mfe_pkg::ST_GAIN: begin
        mul_a = mfe_pkg::MUL_AW'(x_q);
        mul_b = {1'b0, gain_q};
      end
      mfe_pkg::ST_DQ: begin
        mul_a = $signed(mfe_pkg::MUL_AW'(cur_d));
        mul_b = RECIP;
      end
      mfe_pkg::ST_DR: begin
        mul_a = $signed(mfe_pkg::MUL_AW'(16'(preg_q >>> RS)));
        mul_b = mfe_pkg::MUL_BW'(DELAY_DEPTH);
      end
      mfe_pkg::ST_RD: mem_re = 1'b1;
      mfe_pkg::ST_RV: begin
        mul_a = mfe_pkg::MUL_AW'(v);
        mul_b = {1'b0, tap_tab_q[t_q[IW-1:0]][31:16]};
      end
      mfe_pkg::ST_MD: begin
        mul_a = mfe_pkg::MUL_AW'(v_q);
        mul_b = {1'b0, tap_tab_q[t_q[IW-1:0]][15:0]};
      end
      mfe_pkg::ST_MF: begin
        mul_en    = 1'b0;
        mem_we    = 1'b1;
        mem_wdata = mfe_pkg::rnd_sat((mfe_pkg::SUM_W'(g_q) <<< 15)
                                     + mfe_pkg::SUM_W'(preg_q), 15);
      end
      mfe_pkg::ST_F1: begin
        mul_a = $signed({1'b0, wide_q[23:0]});
        mul_b = {1'b0, ffb_q};
      end
      mfe_pkg::ST_F2: begin
        mul_a = mfe_pkg::MUL_AW'($signed(wide_q[47:24]));
        mul_b = {1'b0, ffb_q};
      end
      mfe_pkg::ST_F3: begin
        mem_we    = 1'b1;
        mem_waddr = FINAL_BASE + MW'(ptr_q);
        mem_wdata = mfe_pkg::rnd_sat(sum_q + (mfe_pkg::SUM_W'(preg_q) <<< 24), 30);
        mul_a     = mfe_pkg::MUL_AW'(g_q);
        mul_b     = {1'b0, dry_q};
      end
      mfe_pkg::ST_O1: begin
        mul_a = $signed({1'b0, acc_q[23:0]});
        mul_b = {1'b0, wet_q};
      end
      mfe_pkg::ST_O2: begin
        mul_a = mfe_pkg::MUL_AW'($signed(acc_q[47:24]));
        mul_b = {1'b0, wet_q};
      end
      mfe_pkg::ST_O3: mul_en = 1'b0;
      default: mul_en = 1'b0;
    endcase
  end

  // delay reduction: quotient estimate is exact or one low
  always_comb begin
    rdiff = DW'(cur_d) - DW'(preg_q[16:0]);
    if (rdiff >= DW'(DELAY_DEPTH)) rdiff = rdiff - DW'(DELAY_DEPTH);
    ssum = (AW + 1)'(ptr_q) + (AW + 1)'(r_q);
    if (ssum >= DEPTH_C) ssum = ssum - DEPTH_C;
    if (cp_q[cur_ln] >= s_q) begin
      pdiff = (AW + 1)'(cp_q[cur_ln]) - (AW + 1)'(s_q);
    end else begin
      pdiff = (AW + 1)'(cp_q[cur_ln]) + DEPTH_C - (AW + 1)'(s_q);
    end
  end

  // line memory
  always_ff @(posedge clk_i) begin
    if (mem_we) echo_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= $signed(echo_mem[mem_raddr]);
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (mul_en) preg_q <= prod;
    unique case (state_q)
      mfe_pkg::ST_IDLE: x_q <= in_s.sample_in;
      mfe_pkg::ST_GSAT: begin
        g_q   <= mfe_pkg::rnd_sat(mfe_pkg::SUM_W'(preg_q), 12);
        acc_q <= '0;
      end
      mfe_pkg::ST_DA: r_q <= NEED_MOD ? AW'(rdiff) : AW'(cur_d);
      mfe_pkg::ST_DS: s_q <= AW'(ssum);
      mfe_pkg::ST_RD: vld_q <= pdiff < cnt_q[cur_ln];
      mfe_pkg::ST_RV: begin
        v_q <= v;
        if (fin_q) acc_q <= acc_q + (mfe_pkg::ACC_W'(v) <<< 15);
      end
      mfe_pkg::ST_MD: acc_q <= acc_q + mfe_pkg::ACC_W'(preg_q);
      mfe_pkg::ST_F0: wide_q <= (mfe_pkg::ACC_W'(g_q) <<< 15) + acc_q;
      mfe_pkg::ST_F2: sum_q <= mfe_pkg::SUM_W'(preg_q);
      mfe_pkg::ST_O1: sum_q <= mfe_pkg::SUM_W'(preg_q) <<< 15;
      mfe_pkg::ST_O2: sum_q <= sum_q + mfe_pkg::SUM_W'(preg_q);
      default: ;
    endcase
  end

  // control, configuration and fill counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mfe_pkg::ST_IDLE;
      t_q       <= '0;
      fin_q     <= 1'b0;
      ptr_q     <= '0;
      base_q    <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
      gain_q    <= mfe_pkg::GAIN_RST;
      dry_q     <= mfe_pkg::DRY_RST;
      wet_q     <= '0;
      ffb_q     <= '0;
      fdly_q    <= mfe_pkg::FDLY_RST;
      tcnt_q    <= '0;
      tsel_q    <= '0;
      tset_q    <= '0;
      for (int i = 0; i < MAX_TAPS; i++) tap_tab_q[i] <= '0;
      for (int l = 0; l < NUM_LINES; l++) begin
        cp_q[l]  <= '0;
        cnt_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_vld_q && out_s.ready && state_q != mfe_pkg::ST_O3) out_vld_q <= 1'b0;
      unique case (state_q)
        mfe_pkg::ST_GSAT: begin
          t_q    <= '0;
          base_q <= '0;
          fin_q  <= (tcnt_q == '0);
        end
        mfe_pkg::ST_MF: begin
          if (cnt_q[t_q] != DEPTH_C) cnt_q[t_q] <= cnt_q[t_q] + 1'b1;
          t_q    <= t_q + 1'b1;
          base_q <= base_q + MW'(DELAY_DEPTH);
          fin_q  <= last_tap;
        end
        mfe_pkg::ST_F3: begin
          if (cnt_q[MAX_TAPS] != DEPTH_C) cnt_q[MAX_TAPS] <= cnt_q[MAX_TAPS] + 1'b1;
          base_q <= FINAL_BASE;
        end
        mfe_pkg::ST_O3: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            out_q     <= y;
            fin_q     <= 1'b0;
            ptr_q     <= (ptr_q == '0) ? AW'(DELAY_DEPTH - 1) : ptr_q - 1'b1;
          end
        end
        default: ;
      endcase
      if (cfg_wr) begin
        unique case (ridx)
          mfe_pkg::REG_INPUT_GAIN:  gain_q <= pwdata[15:0];
          mfe_pkg::REG_DRY_MIX:     dry_q  <= pwdata[15:0];
          mfe_pkg::REG_WET_MIX:     wet_q  <= pwdata[15:0];
          mfe_pkg::REG_FINAL_FB:    ffb_q  <= pwdata[15:0];
          mfe_pkg::REG_FINAL_DELAY: fdly_q <= pwdata[15:0];
          mfe_pkg::REG_TAP_COUNT: begin
            // newly enabled lines start empty
            for (int l = 0; l < MAX_TAPS; l++) begin
              if (l >= int'(tcnt_q) && l < int'(ncnt)) begin
                cp_q[l]  <= ptr_q;
                cnt_q[l] <= '0;
              end
            end
            tcnt_q <= ncnt;
          end
          mfe_pkg::REG_TAP_SELECT:  tsel_q <= pwdata[3:0];
          mfe_pkg::REG_TAP_SETTING: begin
            tset_q <= pwdata[47:0];
            if ({1'b0, tsel_q} < 5'(MAX_TAPS)) begin
              tap_tab_q[tsel_q[IW-1:0]] <= pwdata[47:0];
              cp_q[LW'(tsel_q[IW-1:0])]  <= ptr_q;
              cnt_q[LW'(tsel_q[IW-1:0])] <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q < AW'(DELAY_DEPTH - 1) || ptr_q == AW'(DELAY_DEPTH - 1))
    else $error("line pointer out of range");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q != mfe_pkg::ST_IDLE)
    else $error("line write outside a transaction");

  a_tap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfe_pkg::ST_MF) |-> CMPW'(t_q) < CMPW'(tcnt_q))
    else $error("tap step beyond tap count");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[cur_ln] <= DEPTH_C)
    else $error("fill count beyond depth");

  a_out_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfe_pkg::ST_O3 && out_free) |=> out_vld_q && state_q == mfe_pkg::ST_IDLE)
    else $error("result not presented");

endmodule
